FILE: src/tnc2g_pkg.sv
package tnc2g_pkg;

	localparam int DEF_MAX_FRAME_BYTES = 1024;

	localparam int OUT_W = 10;
	localparam int OUT_MAX = 1023;

	localparam logic [3:0] V_ACCEPT    = 4'd0;
	localparam logic [3:0] V_BAD_SRC   = 4'd1;
	localparam logic [3:0] V_FORB_SRC  = 4'd2;
	localparam logic [3:0] V_NO_GT     = 4'd3;
	localparam logic [3:0] V_BAD_DST   = 4'd4;
	localparam logic [3:0] V_FORB_DST  = 4'd5;
	localparam logic [3:0] V_VIA_SEP   = 4'd6;
	localparam logic [3:0] V_BAD_VIA   = 4'd7;
	localparam logic [3:0] V_FORB_VIA  = 4'd8;
	localparam logic [3:0] V_QUERY     = 4'd9;
	localparam logic [3:0] V_OVERLONG  = 4'd10;

	localparam logic [2:0] PH_SRC  = 3'd0;
	localparam logic [2:0] PH_DST  = 3'd1;
	localparam logic [2:0] PH_VIA  = 3'd2;
	localparam logic [2:0] PH_PAY0 = 3'd3;
	localparam logic [2:0] PH_PAY1 = 3'd4;

	localparam logic [2:0] CS_BODY  = 3'd0;
	localparam logic [2:0] CS_DASH  = 3'd1;
	localparam logic [2:0] CS_DIG1  = 3'd2;
	localparam logic [2:0] CS_DIG2  = 3'd3;
	localparam logic [2:0] CS_STAR  = 3'd4;

	localparam int NUM_WORDS = 9;

	localparam logic [NUM_WORDS-1:0] MASK_SRC = 9'h07F;
	localparam logic [NUM_WORDS-1:0] MASK_DST = 9'h1F8;
	localparam logic [NUM_WORDS-1:0] MASK_VIA = 9'h198;

	typedef logic [5:0][7:0] prefix_t;

	// Element 0 of each entry holds the first character.
	localparam prefix_t WORDS [NUM_WORDS] = '{
		{8'd0, 8'd0, "E", "D", "I", "W"},
		{8'd0, "Y", "A", "L", "E", "R"},
		{8'd0, "E", "C", "A", "R", "T"},
		{8'd0, "P", "I", "P", "C", "T"},
		{8'd0, "X", "X", "P", "C", "T"},
		{"L", "L", "A", "C", "0", "N"},
		{"L", "L", "A", "C", "O", "N"},
		{"E", "T", "A", "G", "O", "N"},
		{"Y", "L", "N", "O", "F", "R"}
	};

	localparam logic [2:0] WORD_LEN [NUM_WORDS] = '{
		3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd6, 3'd6, 3'd6
	};

	typedef struct packed {
		logic [3:0]       verdict;
		logic [OUT_W-1:0] header_length;
		logic [OUT_W-1:0] payload_offset;
		logic [3:0]       levels;
	} result_t;

endpackage

FILE: src/tnc2g_prefix.sv
module tnc2g_prefix (
	input  tnc2g_pkg::prefix_t                  field_prefix,
	input  logic [2:0]                          char_count,
	input  logic [tnc2g_pkg::NUM_WORDS-1:0]     mask,
	output logic                                hit
);

	always_comb begin
		logic same;
		hit = 1'b0;
		for (int i = 0; i < tnc2g_pkg::NUM_WORDS; i++) begin
			same = (char_count >= tnc2g_pkg::WORD_LEN[i]);
			for (int j = 0; j < 6; j++) begin
				if ((3'(j) < tnc2g_pkg::WORD_LEN[i]) &&
				    (field_prefix[j] != tnc2g_pkg::WORDS[i][j])) begin
					same = 1'b0;
				end
			end
			if (mask[i] && same) begin
				hit = 1'b1;
			end
		end
	end

endmodule

FILE: src/tnc2g_parser.sv
module tnc2g_parser #(
	parameter int MAX_FRAME_BYTES = tnc2g_pkg::DEF_MAX_FRAME_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          frame_byte,
	input  logic                last_byte,
	output tnc2g_pkg::result_t  result
);

	localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
	localparam int EW = (PW + 1 > tnc2g_pkg::OUT_W) ? PW + 1 : tnc2g_pkg::OUT_W;

	logic [2:0]          phase_q, phase_d;
	logic [2:0]          sub_q, sub_d;
	tnc2g_pkg::prefix_t  prefix_q, prefix_d;
	logic [2:0]          count_q, count_d;
	logic [PW-1:0]       pos_q, pos_d;
	logic [PW-1:0]       inner_q, inner_d;
	logic [PW-1:0]       colon_q, colon_d;
	logic [3:0]          pend_q, pend_d;
	logic [3:0]          unwrap_q, unwrap_d;

	logic [tnc2g_pkg::NUM_WORDS-1:0] mask;
	logic                            hit;

	always_comb begin
		unique case (phase_q)
			tnc2g_pkg::PH_SRC: mask = tnc2g_pkg::MASK_SRC;
			tnc2g_pkg::PH_DST: mask = tnc2g_pkg::MASK_DST;
			default:           mask = tnc2g_pkg::MASK_VIA;
		endcase
	end

	tnc2g_prefix u_prefix (
		.field_prefix (prefix_q),
		.char_count   (count_q),
		.mask         (mask),
		.hit          (hit)
	);

	always_comb begin
		logic       digit;
		logic       alnum;
		logic       do_end;
		logic       empty;
		logic       term;
		logic       begin_fld;
		logic [3:0] fin;
		logic [EW-1:0] hl_w;
		logic [EW-1:0] po_w;

		phase_d   = phase_q;
		sub_d     = sub_q;
		prefix_d  = prefix_q;
		count_d   = count_q;
		inner_d   = inner_q;
		colon_d   = colon_q;
		pend_d    = pend_q;
		unwrap_d  = unwrap_q;
		do_end    = 1'b0;
		empty     = 1'b0;
		begin_fld = 1'b0;

		digit = (frame_byte >= "0") && (frame_byte <= "9");
		alnum = digit || ((frame_byte >= "A") && (frame_byte <= "Z"));
		term  = (frame_byte == ">") || (frame_byte == ",") || (frame_byte == ":");

		if (pos_q >= PW'(MAX_FRAME_BYTES)) begin
			pend_d = tnc2g_pkg::V_OVERLONG;
		end else if (pend_q == tnc2g_pkg::V_ACCEPT) begin
			if (phase_q <= tnc2g_pkg::PH_VIA) begin
				unique case (sub_q)
					tnc2g_pkg::CS_BODY: begin
						if (alnum) begin
							if (count_q < 3'd6) begin
								prefix_d[count_q] = frame_byte;
							end
							if (count_q < 3'd7) begin
								count_d = count_q + 3'd1;
							end
						end else if (frame_byte == "-") begin
							sub_d = tnc2g_pkg::CS_DASH;
						end else if (frame_byte == "*") begin
							sub_d = tnc2g_pkg::CS_STAR;
						end else begin
							do_end = 1'b1;
							empty  = (count_q == 3'd0);
						end
					end
					tnc2g_pkg::CS_DASH: begin
						if ((frame_byte >= "1") && (frame_byte <= "9")) begin
							sub_d = tnc2g_pkg::CS_DIG1;
						end else if (frame_byte == "0") begin
							sub_d = tnc2g_pkg::CS_DIG2;
						end else if (frame_byte == "*") begin
							sub_d = tnc2g_pkg::CS_STAR;
						end else begin
							do_end = 1'b1;
						end
					end
					tnc2g_pkg::CS_DIG1: begin
						if (digit) begin
							sub_d = tnc2g_pkg::CS_DIG2;
						end else if (frame_byte == "*") begin
							sub_d = tnc2g_pkg::CS_STAR;
						end else begin
							do_end = 1'b1;
						end
					end
					tnc2g_pkg::CS_DIG2: begin
						if (frame_byte == "*") begin
							sub_d = tnc2g_pkg::CS_STAR;
						end else begin
							do_end = 1'b1;
						end
					end
					default: begin
						do_end = 1'b1;
					end
				endcase

				if (do_end) begin
					priority if (empty || !term) begin
						pend_d = (phase_q == tnc2g_pkg::PH_SRC) ? tnc2g_pkg::V_BAD_SRC :
						         (phase_q == tnc2g_pkg::PH_DST) ? tnc2g_pkg::V_BAD_DST :
						                                          tnc2g_pkg::V_BAD_VIA;
					end else if (hit) begin
						pend_d = (phase_q == tnc2g_pkg::PH_SRC) ? tnc2g_pkg::V_FORB_SRC :
						         (phase_q == tnc2g_pkg::PH_DST) ? tnc2g_pkg::V_FORB_DST :
						                                          tnc2g_pkg::V_FORB_VIA;
					end else if (phase_q == tnc2g_pkg::PH_SRC) begin
						if (frame_byte == ">") begin
							phase_d   = tnc2g_pkg::PH_DST;
							begin_fld = 1'b1;
						end else begin
							pend_d = tnc2g_pkg::V_NO_GT;
						end
					end else if (frame_byte == ":") begin
						colon_d = pos_q;
						phase_d = tnc2g_pkg::PH_PAY0;
					end else if (frame_byte == ",") begin
						phase_d   = tnc2g_pkg::PH_VIA;
						begin_fld = 1'b1;
					end else begin
						pend_d = tnc2g_pkg::V_VIA_SEP;
					end
				end
			end else if (phase_q == tnc2g_pkg::PH_PAY0) begin
				if (frame_byte == "?") begin
					pend_d = tnc2g_pkg::V_QUERY;
				end else if (frame_byte == "}") begin
					if (unwrap_q < 4'd15) begin
						unwrap_d = unwrap_q + 4'd1;
					end
					inner_d   = pos_q + PW'(1);
					phase_d   = tnc2g_pkg::PH_SRC;
					begin_fld = 1'b1;
				end else begin
					phase_d = tnc2g_pkg::PH_PAY1;
				end
			end
		end

		if (begin_fld) begin
			sub_d    = tnc2g_pkg::CS_BODY;
			count_d  = 3'd0;
			prefix_d = '0;
		end

		pos_d = (pos_q < PW'(MAX_FRAME_BYTES)) ? pos_q + PW'(1) : pos_q;

		fin = pend_d;
		if (pend_d == tnc2g_pkg::V_ACCEPT) begin
			if (phase_d == tnc2g_pkg::PH_SRC) begin
				fin = tnc2g_pkg::V_BAD_SRC;
			end else if (phase_d == tnc2g_pkg::PH_DST) begin
				fin = tnc2g_pkg::V_BAD_DST;
			end else if (phase_d == tnc2g_pkg::PH_VIA) begin
				fin = tnc2g_pkg::V_BAD_VIA;
			end
		end

		hl_w = EW'(colon_d) - EW'(inner_d);
		po_w = EW'(colon_d) + EW'(1);

		result.verdict = fin;
		result.levels  = unwrap_d;
		if (fin == tnc2g_pkg::V_ACCEPT) begin
			result.header_length  = (hl_w > EW'(tnc2g_pkg::OUT_MAX)) ?
				tnc2g_pkg::OUT_W'(tnc2g_pkg::OUT_MAX) : hl_w[tnc2g_pkg::OUT_W-1:0];
			result.payload_offset = (po_w > EW'(tnc2g_pkg::OUT_MAX)) ?
				tnc2g_pkg::OUT_W'(tnc2g_pkg::OUT_MAX) : po_w[tnc2g_pkg::OUT_W-1:0];
		end else begin
			result.header_length  = '0;
			result.payload_offset = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= tnc2g_pkg::PH_SRC;
			sub_q    <= tnc2g_pkg::CS_BODY;
			prefix_q <= '0;
			count_q  <= '0;
			pos_q    <= '0;
			inner_q  <= '0;
			colon_q  <= '0;
			pend_q   <= tnc2g_pkg::V_ACCEPT;
			unwrap_q <= '0;
		end else if (step) begin
			if (last_byte) begin
				phase_q  <= tnc2g_pkg::PH_SRC;
				sub_q    <= tnc2g_pkg::CS_BODY;
				prefix_q <= '0;
				count_q  <= '0;
				pos_q    <= '0;
				inner_q  <= '0;
				colon_q  <= '0;
				pend_q   <= tnc2g_pkg::V_ACCEPT;
				unwrap_q <= '0;
			end else begin
				phase_q  <= phase_d;
				sub_q    <= sub_d;
				prefix_q <= prefix_d;
				count_q  <= count_d;
				pos_q    <= pos_d;
				inner_q  <= inner_d;
				colon_q  <= colon_d;
				pend_q   <= pend_d;
				unwrap_q <= unwrap_d;
			end
		end
	end

endmodule

FILE: src/tnc2_rx_gate_filter.sv
// Receive-gate filter for TNC2 text packets. Bytes of one packet enter on the
// slave stream, one word per byte with tlast on the final byte, and the block
// parses SOURCE>DEST,VIA...:payload as they arrive, unwrapping third-party
// packets that begin with a brace. Exactly one result word leaves for each
// packet, carrying the verdict, the header length, the payload offset and the
// unwrap count. The block takes one byte per clock cycle except while a last
// byte waits; the per-byte parser update sits between the input register and
// the result register, which loads the result as the last byte is consumed.
// Only a last byte can wait in the input register, and only while the
// previous result has not been taken.
module tnc2_rx_gate_filter #(
	parameter int MAX_FRAME_BYTES = tnc2g_pkg::DEF_MAX_FRAME_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] frame_byte
	input  logic        s_tlast,  // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // [3:0] verdict, [13:4] header_length,
	                              // [23:14] payload_offset, [27:24] third_party_levels
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               last_s1;
	logic               consume;
	logic               out_free;
	logic               out_valid_q;
	tnc2g_pkg::result_t out_q;
	tnc2g_pkg::result_t result;

	assign out_free = !out_valid_q || m_tready;
	assign consume  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	tnc2g_parser #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (consume),
		.frame_byte (byte_s1),
		.last_byte  (last_s1),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_q.levels, out_q.payload_offset, out_q.header_length,
		out_q.verdict};

`ifndef SYNTHESIS
	a_stall_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s_tready |-> last_s1 && out_valid_q && !m_tready)
		else $error("input register stalled without a waiting result");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s1 && last_s1))
		else $error("result appeared without a last byte");

	a_reject_zero_offsets: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (out_q.verdict != tnc2g_pkg::V_ACCEPT) |->
		(out_q.header_length == '0) && (out_q.payload_offset == '0))
		else $error("rejected packet carries offsets");

	a_accept_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (out_q.verdict == tnc2g_pkg::V_ACCEPT) |->
		(out_q.header_length <= out_q.payload_offset) && (out_q.payload_offset != '0))
		else $error("accepted header length exceeds payload offset");

	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> out_q.verdict <= tnc2g_pkg::V_OVERLONG)
		else $error("verdict code out of range");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int FRAME_MAX = tnc2g_pkg::DEF_MAX_FRAME_BYTES;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	tnc2_rx_gate_filter #(
		.MAX_FRAME_BYTES(FRAME_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// Parser state of the predictor.
	logic [2:0]          g_phase;
	logic [2:0]          g_sub;
	tnc2g_pkg::prefix_t  g_prefix;
	int                  g_count;
	int                  g_pos;
	int                  g_inner;
	int                  g_colon;
	logic [3:0]          g_verdict;
	logic [3:0]          g_levels;

	tnc2g_pkg::result_t verdicts_due[$];
	logic [7:0]         pkt_buf[$];

	int  n_fail = 0;
	int  n_verdicts = 0;
	int  bytes_sent = 0;
	int  cycle_count = 0;
	bit  tx_idle_en = 1'b1;
	bit  rx_idle_en = 1'b1;
	bit  hold_rq = 1'b0;
	int  hold_len = 0;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tlast = 1'b0;
		m_tready = 1'b0;
	end

	always #10 clk = ~clk;

	task automatic gate_field_start();
		g_sub = tnc2g_pkg::CS_BODY;
		g_count = 0;
		g_prefix = '0;
	endtask

	task automatic gate_clear();
		g_phase = tnc2g_pkg::PH_SRC;
		gate_field_start();
		g_pos = 0;
		g_inner = 0;
		g_colon = 0;
		g_verdict = tnc2g_pkg::V_ACCEPT;
		g_levels = 4'd0;
	endtask

	function automatic bit gate_banned(logic [tnc2g_pkg::NUM_WORDS-1:0] mask);
		int i;
		int n;
		bit same;
		for (i = 0; i < tnc2g_pkg::NUM_WORDS; i++) begin
			if (mask[i] && g_count >= int'(tnc2g_pkg::WORD_LEN[i])) begin
				same = 1'b1;
				for (n = 0; n < int'(tnc2g_pkg::WORD_LEN[i]); n++)
					if (g_prefix[n] != tnc2g_pkg::WORDS[i][n])
						same = 1'b0;
				if (same)
					return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic gate_close_field(logic [7:0] c, bit empty);
		logic [3:0] bad;
		logic [3:0] forb;
		logic [tnc2g_pkg::NUM_WORDS-1:0] mask;
		case (g_phase)
			tnc2g_pkg::PH_SRC: begin
				bad = tnc2g_pkg::V_BAD_SRC;
				forb = tnc2g_pkg::V_FORB_SRC;
				mask = tnc2g_pkg::MASK_SRC;
			end
			tnc2g_pkg::PH_DST: begin
				bad = tnc2g_pkg::V_BAD_DST;
				forb = tnc2g_pkg::V_FORB_DST;
				mask = tnc2g_pkg::MASK_DST;
			end
			tnc2g_pkg::PH_VIA: begin
				bad = tnc2g_pkg::V_BAD_VIA;
				forb = tnc2g_pkg::V_FORB_VIA;
				mask = tnc2g_pkg::MASK_VIA;
			end
			default: return;
		endcase
		if (empty || !(c == ">" || c == "," || c == ":")) begin
			g_verdict = bad;
		end else if (gate_banned(mask)) begin
			g_verdict = forb;
		end else if (g_phase == tnc2g_pkg::PH_SRC) begin
			if (c == ">") begin
				g_phase = tnc2g_pkg::PH_DST;
				gate_field_start();
			end else begin
				g_verdict = tnc2g_pkg::V_NO_GT;
			end
		end else if (c == ":") begin
			g_colon = g_pos;
			g_phase = tnc2g_pkg::PH_PAY0;
		end else if (c == ",") begin
			g_phase = tnc2g_pkg::PH_VIA;
			gate_field_start();
		end else begin
			g_verdict = tnc2g_pkg::V_VIA_SEP;
		end
	endtask

	task automatic gate_call_char(logic [7:0] c);
		bit digit;
		digit = (c >= "0" && c <= "9");
		case (g_sub)
			tnc2g_pkg::CS_BODY: begin
				if (digit || (c >= "A" && c <= "Z")) begin
					if (g_count < 6)
						g_prefix[g_count] = c;
					if (g_count < 7)
						g_count++;
				end else if (c == "-") begin
					g_sub = tnc2g_pkg::CS_DASH;
				end else if (c == "*") begin
					g_sub = tnc2g_pkg::CS_STAR;
				end else begin
					gate_close_field(c, g_count == 0);
				end
			end
			tnc2g_pkg::CS_DASH: begin
				if (c >= "1" && c <= "9")
					g_sub = tnc2g_pkg::CS_DIG1;
				else if (c == "0")
					g_sub = tnc2g_pkg::CS_DIG2;
				else if (c == "*")
					g_sub = tnc2g_pkg::CS_STAR;
				else
					gate_close_field(c, 1'b0);
			end
			tnc2g_pkg::CS_DIG1: begin
				if (digit)
					g_sub = tnc2g_pkg::CS_DIG2;
				else if (c == "*")
					g_sub = tnc2g_pkg::CS_STAR;
				else
					gate_close_field(c, 1'b0);
			end
			tnc2g_pkg::CS_DIG2: begin
				if (c == "*")
					g_sub = tnc2g_pkg::CS_STAR;
				else
					gate_close_field(c, 1'b0);
			end
			default: gate_close_field(c, 1'b0);
		endcase
	endtask

	task automatic gate_take_byte(logic [7:0] c, bit last);
		tnc2g_pkg::result_t r;
		int hl;
		int po;
		if (g_pos >= FRAME_MAX) begin
			g_verdict = tnc2g_pkg::V_OVERLONG;
		end else if (g_verdict == tnc2g_pkg::V_ACCEPT) begin
			if (g_phase <= tnc2g_pkg::PH_VIA) begin
				gate_call_char(c);
			end else if (g_phase == tnc2g_pkg::PH_PAY0) begin
				if (c == "?") begin
					g_verdict = tnc2g_pkg::V_QUERY;
				end else if (c == "}") begin
					if (g_levels != 4'd15)
						g_levels++;
					g_inner = g_pos + 1;
					g_phase = tnc2g_pkg::PH_SRC;
					gate_field_start();
				end else begin
					g_phase = tnc2g_pkg::PH_PAY1;
				end
			end
		end
		if (g_pos < FRAME_MAX)
			g_pos++;
		if (last) begin
			if (g_verdict == tnc2g_pkg::V_ACCEPT) begin
				if (g_phase == tnc2g_pkg::PH_SRC)
					g_verdict = tnc2g_pkg::V_BAD_SRC;
				else if (g_phase == tnc2g_pkg::PH_DST)
					g_verdict = tnc2g_pkg::V_BAD_DST;
				else if (g_phase == tnc2g_pkg::PH_VIA)
					g_verdict = tnc2g_pkg::V_BAD_VIA;
			end
			r.verdict = g_verdict;
			r.header_length = '0;
			r.payload_offset = '0;
			r.levels = g_levels;
			if (g_verdict == tnc2g_pkg::V_ACCEPT) begin
				hl = g_colon - g_inner;
				po = g_colon + 1;
				if (hl > tnc2g_pkg::OUT_MAX)
					hl = tnc2g_pkg::OUT_MAX;
				if (po > tnc2g_pkg::OUT_MAX)
					po = tnc2g_pkg::OUT_MAX;
				r.header_length = tnc2g_pkg::OUT_W'(hl);
				r.payload_offset = tnc2g_pkg::OUT_W'(po);
			end
			verdicts_due.push_back(r);
			n_verdicts++;
			gate_clear();
		end
	endtask

	initial gate_clear();

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			gate_take_byte(s_tdata, s_tlast);
	end

	always @(posedge clk) begin
		tnc2g_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdicts_due.size() == 0) begin
				$error("result word with no packet outstanding: %h", m_tdata);
				n_fail++;
			end else begin
				want = verdicts_due.pop_front();
				if (m_tdata[3:0] !== want.verdict) begin
					$error("verdict: expected %0d, got %0d", want.verdict, m_tdata[3:0]);
					n_fail++;
				end
				if (m_tdata[13:4] !== want.header_length) begin
					$error("header_length: expected %0d, got %0d",
						want.header_length, m_tdata[13:4]);
					n_fail++;
				end
				if (m_tdata[23:14] !== want.payload_offset) begin
					$error("payload_offset: expected %0d, got %0d",
						want.payload_offset, m_tdata[23:14]);
					n_fail++;
				end
				if (m_tdata[27:24] !== want.levels) begin
					$error("third_party_levels: expected %0d, got %0d",
						want.levels, m_tdata[27:24]);
					n_fail++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL tnc2_rx_gate_filter");
			$finish;
		end
	end

	// Result receiver. A hold request stops it; hold_len sets how long.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = rx_idle_en ? $urandom_range(0, 3) : 0;
			if (hold_rq) begin
				stall = hold_len;
				hold_rq = 1'b0;
			end
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid && !hold_rq)
				@(posedge clk);
		end
	end

	task automatic put_text(string t);
		int i;
		for (i = 0; i < t.len(); i++)
			pkt_buf.push_back(t[i]);
	endtask

	task automatic send_word(logic [7:0] b, bit last);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_pkt();
		int i;
		for (i = 0; i < pkt_buf.size(); i++)
			send_word(pkt_buf[i], i == pkt_buf.size() - 1);
		pkt_buf.delete();
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (verdicts_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_text(string t);
		put_text(t);
		send_pkt();
	endtask

	function automatic logic [7:0] rand_alnum();
		int k;
		k = $urandom_range(0, 35);
		return (k < 26) ? 8'("A" + k) : 8'("0" + k - 26);
	endfunction

	task automatic put_call();
		string banned_words[9];
		int n;
		int r;
		banned_words = '{"WIDE", "RELAY", "TRACE", "TCPIP", "TCPXX",
			"N0CALL", "NOCALL", "NOGATE", "RFONLY"};
		if ($urandom_range(0, 6) == 0) begin
			put_text(banned_words[$urandom_range(0, 8)]);
			n = $urandom_range(0, 2);
		end else begin
			n = $urandom_range(1, 8);
		end
		repeat (n) pkt_buf.push_back(rand_alnum());
		if ($urandom_range(0, 2) == 0) begin
			pkt_buf.push_back("-");
			r = $urandom_range(0, 3);
			if (r >= 1)
				pkt_buf.push_back(8'("0" + $urandom_range(0, 9)));
			if (r >= 2)
				pkt_buf.push_back(8'("0" + $urandom_range(0, 9)));
		end
		if ($urandom_range(0, 6) == 0)
			pkt_buf.push_back("*");
	endtask

	task automatic put_frame(int depth);
		int r;
		put_call();
		pkt_buf.push_back(">");
		put_call();
		repeat ($urandom_range(0, 3)) begin
			pkt_buf.push_back(",");
			put_call();
		end
		pkt_buf.push_back(":");
		r = $urandom_range(0, 9);
		if (r == 0) begin
			pkt_buf.push_back("?");
		end else if (r == 1 && depth < 3) begin
			pkt_buf.push_back("}");
			put_frame(depth + 1);
			return;
		end
		repeat ($urandom_range(0, 12)) pkt_buf.push_back(8'($urandom_range(32, 126)));
	endtask

	task automatic test_directed();
		put_text("K1ABC>APRS,WIDE1-1:!hello");
		send_pkt();
		send_text("K1ABC-9*>APRS:");
		send_text("k1abc>APRS:x");
		send_text("WIDE1-1>APRS:x");
		send_text("K1ABC,APRS:x");
		send_text("K1ABC>:x");
		send_text("K1ABC>NOGATE:x");
		send_text("K1ABC>APRS>X:x");
		send_text("K1ABC>APRS,:x");
		send_text("K1ABC>APRS,TCPIP*:x");
		send_text("K1ABC>APRS:?IGATE?");
		send_text("K1ABC>APRS:}W1AW>APRS,TCPIP:inner");
		send_text("K1ABC>APRS,RELAY:}W1AW-10>APRS,WIDE2-2*:inner");
		send_text("K1ABC>APRS:}");
		send_text("K1ABC>");
		send_text("K1ABC>APRS,");
		send_text("A-0*>B-10,C-9,D-*,E*:x");
		send_text("A-00>B:x");
		send_text("ABCDEFGHIJ>RELA,TRACEX:x");
		send_text("TCPIPX>APRS:x");
		pkt_buf.push_back(8'h00);
		send_pkt();
		pkt_buf.push_back(8'hFF);
		send_pkt();
		repeat (16) put_text("A>B:}");
		send_text("C>D:x");
		// The colon sits on the last position below the frame limit.
		repeat (FRAME_MAX - 3) pkt_buf.push_back("A");
		send_text(">B:");
		// The query sits on the last position below the limit; the next byte overrides it.
		repeat (FRAME_MAX - 4) pkt_buf.push_back("A");
		send_text(">B:?y");
		wait_drain();
	endtask

	task automatic test_random();
		int start_bytes;
		int pkts;
		int kind;
		int k;
		start_bytes = bytes_sent;
		pkts = 0;
		while (bytes_sent - start_bytes < 500 || pkts < 20) begin
			if (pkts % 25 == 0) begin
				tx_idle_en = ($urandom_range(0, 3) != 0);
				rx_idle_en = ($urandom_range(0, 3) != 0);
			end
			kind = $urandom_range(0, 19);
			if (kind < 3) begin
				repeat ($urandom_range(1, 16)) pkt_buf.push_back(8'($urandom_range(0, 255)));
			end else begin
				put_frame(0);
				if (kind < 6) begin
					k = $urandom_range(0, pkt_buf.size() - 1);
					pkt_buf[k] = 8'($urandom_range(0, 255));
				end else if (kind < 8) begin
					k = $urandom_range(1, pkt_buf.size());
					pkt_buf = pkt_buf[0:k-1];
				end
			end
			send_pkt();
			pkts++;
		end
		wait_drain();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	task automatic test_backpressure();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		hold_len = 300;
		hold_rq = 1'b1;
		repeat (12) begin
			put_frame(0);
			send_pkt();
		end
		wait_drain();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	task automatic test_drain_pause();
		repeat (5) begin
			put_frame(0);
			send_pkt();
			wait_drain();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_drain_pause();
		test_backpressure();
		test_random();
		wait_drain();
		repeat (8) @(posedge clk);
		if (n_fail == 0)
			$display("PASS tnc2_rx_gate_filter");
		else
			$display("FAIL tnc2_rx_gate_filter");
		$finish;
	end

endmodule

FILE: tnc2_rx_gate_filter.f
src/tnc2g_pkg.sv
src/tnc2g_prefix.sv
src/tnc2g_parser.sv
src/tnc2_rx_gate_filter.sv
tb/tb_top.sv
